/* rtl/core/csbw_pkg.sv */
// Shared types, constants and register codes for the cascade shadow blend weight block.
`default_nettype none

package csbw_pkg;

  localparam int unsigned MAX_CASCADES = 4;
  localparam int unsigned NUM_EDGES    = MAX_CASCADES + 1;
  localparam int unsigned EDGE_IDX_W   = $clog2(NUM_EDGES);

  localparam int unsigned EDGE_W   = 32;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned FADE_W   = 16;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Signed widths of the band arithmetic.
  localparam int unsigned DIFF_W = EDGE_W + 1;          // edge differences
  localparam int unsigned W_W    = DIFF_W + FADE_W + 1; // thin * fade
  localparam int unsigned NUM_W  = W_W + 1;             // 2*diff*2^16 + w
  localparam int unsigned DIV_W  = W_W;                 // remainder and divisor

  localparam int unsigned T_W       = 16;
  localparam int unsigned DIV_STEPS = T_W;
  localparam int unsigned SQ_W      = 2 * T_W;
  localparam int unsigned M_W       = T_W + 2;
  localparam int unsigned P_W       = SQ_W + M_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_ZERO = '0;
  localparam logic [M_W-1:0]      THREE_ONE  = M_W'(3 * 65536);
  localparam logic [P_W-1:0]      ROUND_HALF = P_W'(64'd1 << 31);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EDGE_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EDGE_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EDGE_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EDGE_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EDGE_4  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CASCADE_COUNT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_FRACTION = 3'd6;

  localparam logic [EDGE_W-1:0]  SPLIT_EDGE_0_RST  = 32'd0;
  localparam logic [EDGE_W-1:0]  SPLIT_EDGE_1_RST  = 32'd655360;
  localparam logic [EDGE_W-1:0]  SPLIT_EDGE_2_RST  = 32'd1966080;
  localparam logic [EDGE_W-1:0]  SPLIT_EDGE_3_RST  = 32'd5242880;
  localparam logic [EDGE_W-1:0]  SPLIT_EDGE_4_RST  = 32'd13107200;
  localparam logic [COUNT_W-1:0] CASCADE_COUNT_RST = 3'd4;
  localparam logic [FADE_W-1:0]  FADE_FRACTION_RST = 16'd6554;

  typedef struct packed {
    logic [NUM_EDGES-1:0][EDGE_W-1:0] split_edge;
    logic [COUNT_W-1:0]               cascade_count;
    logic [FADE_W-1:0]                fade_fraction;
  } cfg_t;

  // Front end to divider: either a fixed weight or a division to run.
  typedef struct packed {
    logic                is_div;
    logic [WEIGHT_W-1:0] fix_weight;
    logic [DIV_W-1:0]    rem;
    logic [DIV_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic                is_div;
    logic [WEIGHT_W-1:0] fix_weight;
    logic [DIV_W-1:0]    rem;
    logic [DIV_W-1:0]    den;
    logic [T_W-1:0]      quot;
  } div_stage_t;

  // Divider to smoothstep.
  typedef struct packed {
    logic                is_div;
    logic [WEIGHT_W-1:0] fix_weight;
    logic [T_W-1:0]      quot;
  } smooth_req_t;

endpackage

`default_nettype wire

/* rtl/core/csbw_cfg_regs.sv */
// Configuration register file: split edges, cascade count and fade fraction.
`default_nettype none

module csbw_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [csbw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [csbw_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output csbw_pkg::cfg_t                         cfg_o
);

  csbw_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.split_edge[0]  <= csbw_pkg::SPLIT_EDGE_0_RST;
      cfg_q.split_edge[1]  <= csbw_pkg::SPLIT_EDGE_1_RST;
      cfg_q.split_edge[2]  <= csbw_pkg::SPLIT_EDGE_2_RST;
      cfg_q.split_edge[3]  <= csbw_pkg::SPLIT_EDGE_3_RST;
      cfg_q.split_edge[4]  <= csbw_pkg::SPLIT_EDGE_4_RST;
      cfg_q.cascade_count  <= csbw_pkg::CASCADE_COUNT_RST;
      cfg_q.fade_fraction  <= csbw_pkg::FADE_FRACTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        csbw_pkg::CFG_SPLIT_EDGE_0:  cfg_q.split_edge[0] <= cfg_data_i[csbw_pkg::EDGE_W-1:0];
        csbw_pkg::CFG_SPLIT_EDGE_1:  cfg_q.split_edge[1] <= cfg_data_i[csbw_pkg::EDGE_W-1:0];
        csbw_pkg::CFG_SPLIT_EDGE_2:  cfg_q.split_edge[2] <= cfg_data_i[csbw_pkg::EDGE_W-1:0];
        csbw_pkg::CFG_SPLIT_EDGE_3:  cfg_q.split_edge[3] <= cfg_data_i[csbw_pkg::EDGE_W-1:0];
        csbw_pkg::CFG_SPLIT_EDGE_4:  cfg_q.split_edge[4] <= cfg_data_i[csbw_pkg::EDGE_W-1:0];
        csbw_pkg::CFG_CASCADE_COUNT: begin
          cfg_q.cascade_count <= cfg_data_i[csbw_pkg::COUNT_W-1:0];
        end
        csbw_pkg::CFG_FADE_FRACTION: begin
          cfg_q.fade_fraction <= cfg_data_i[csbw_pkg::FADE_W-1:0];
        end
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/csbw_front.sv */
// Front end: edge select, band width, numerator and denominator, weight classification.
`default_nettype none

module csbw_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  csbw_pkg::cfg_t                         cfg_i,
  input  wire logic                              valid_i,
  input  wire logic [csbw_pkg::INDEX_W-1:0]      boundary_index_i,
  input  wire logic [csbw_pkg::EDGE_W-1:0]       view_depth_i,
  output logic                                   valid_o,
  output csbw_pkg::div_req_t                     req_o
);

  localparam logic [csbw_pkg::COUNT_W-1:0] CountMax = csbw_pkg::COUNT_W'(csbw_pkg::MAX_CASCADES);

  // Stage 1: pick edges, take differences.
  logic [csbw_pkg::COUNT_W-1:0]    count_eff;
  logic                            bvalid;
  logic [csbw_pkg::EDGE_IDX_W-1:0] k_sel;
  logic [csbw_pkg::EDGE_W-1:0]     e_lo, e_mid, e_hi;

  logic                              s1_valid_q, s1_bvalid_q, s1_ge_q;
  logic signed [csbw_pkg::DIFF_W-1:0] s1_lo_q, s1_hi_q, s1_diff_q;
  logic signed [csbw_pkg::DIFF_W-1:0] s1_lo_d, s1_hi_d, s1_diff_d;

  always_comb begin
    count_eff = (cfg_i.cascade_count > CountMax) ? CountMax : cfg_i.cascade_count;
    bvalid    = (boundary_index_i != '0) &&
                (csbw_pkg::COUNT_W'(boundary_index_i) < count_eff);
    // An invalid index still needs in-range edges; its result is forced to zero later.
    k_sel     = bvalid ? csbw_pkg::EDGE_IDX_W'(boundary_index_i)
                       : csbw_pkg::EDGE_IDX_W'(1);
    e_lo      = cfg_i.split_edge[k_sel - csbw_pkg::EDGE_IDX_W'(1)];
    e_mid     = cfg_i.split_edge[k_sel];
    e_hi      = cfg_i.split_edge[k_sel + csbw_pkg::EDGE_IDX_W'(1)];
    s1_lo_d   = $signed({1'b0, e_mid}) - $signed({1'b0, e_lo});
    s1_hi_d   = $signed({1'b0, e_hi}) - $signed({1'b0, e_mid});
    s1_diff_d = $signed({1'b0, view_depth_i}) - $signed({1'b0, e_mid});
  end

  // Stage 2: thinner of the two cascades.
  logic                               s2_valid_q, s2_bvalid_q, s2_ge_q;
  logic signed [csbw_pkg::DIFF_W-1:0] s2_thin_q, s2_diff_q;

  // Stage 3: w = thin * fade.
  logic                               s3_valid_q, s3_bvalid_q, s3_ge_q;
  logic signed [csbw_pkg::W_W-1:0]    s3_w_q, s3_w_d;
  logic signed [csbw_pkg::DIFF_W-1:0] s3_diff_q;
  logic signed [csbw_pkg::FADE_W:0]   fade_s;

  assign fade_s = $signed({1'b0, cfg_i.fade_fraction});
  assign s3_w_d = csbw_pkg::W_W'(s2_thin_q) * csbw_pkg::W_W'(fade_s);

  // Stage 4: numerator and denominator.
  logic                               s4_valid_q, s4_bvalid_q, s4_ge_q, s4_wpos_q;
  logic signed [csbw_pkg::NUM_W-1:0]  s4_num_q, s4_den_q, s4_num_d, s4_den_d;

  assign s4_num_d = (csbw_pkg::NUM_W'(s3_diff_q) <<< (csbw_pkg::FADE_W + 1))
                  + csbw_pkg::NUM_W'(s3_w_q);
  assign s4_den_d = csbw_pkg::NUM_W'(s3_w_q) <<< 1;

  // Stage 5: classify into a fixed weight or a division.
  csbw_pkg::div_req_t req_d;
  logic               num_le_zero, num_ge_den;

  always_comb begin
    num_le_zero       = s4_num_q[csbw_pkg::NUM_W-1] || (s4_num_q == '0);
    num_ge_den        = (s4_num_q >= s4_den_q);
    req_d.is_div      = 1'b0;
    req_d.fix_weight  = csbw_pkg::WEIGHT_ZERO;
    req_d.rem         = s4_num_q[csbw_pkg::DIV_W-1:0];
    req_d.den         = s4_den_q[csbw_pkg::DIV_W-1:0];
    if (!s4_bvalid_q) begin
      req_d.fix_weight = csbw_pkg::WEIGHT_ZERO;
    end else if (!s4_wpos_q) begin
      // empty or negative band: hard step at the edge
      req_d.fix_weight = s4_ge_q ? csbw_pkg::WEIGHT_ONE : csbw_pkg::WEIGHT_ZERO;
    end else if (num_le_zero) begin
      req_d.fix_weight = csbw_pkg::WEIGHT_ZERO;
    end else if (num_ge_den) begin
      req_d.fix_weight = csbw_pkg::WEIGHT_ONE;
    end else begin
      req_d.is_div = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      valid_o    <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_bvalid_q <= bvalid;
      s1_ge_q     <= !s1_diff_d[csbw_pkg::DIFF_W-1];
      s1_lo_q     <= s1_lo_d;
      s1_hi_q     <= s1_hi_d;
      s1_diff_q   <= s1_diff_d;

      s2_bvalid_q <= s1_bvalid_q;
      s2_ge_q     <= s1_ge_q;
      s2_thin_q   <= (s1_lo_q < s1_hi_q) ? s1_lo_q : s1_hi_q;
      s2_diff_q   <= s1_diff_q;

      s3_bvalid_q <= s2_bvalid_q;
      s3_ge_q     <= s2_ge_q;
      s3_w_q      <= s3_w_d;
      s3_diff_q   <= s2_diff_q;

      s4_bvalid_q <= s3_bvalid_q;
      s4_ge_q     <= s3_ge_q;
      s4_wpos_q   <= !s3_w_q[csbw_pkg::W_W-1] && (s3_w_q != '0);
      s4_num_q    <= s4_num_d;
      s4_den_q    <= s4_den_d;

      req_o       <= req_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/csbw_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module csbw_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  csbw_pkg::div_req_t       req_i,
  output logic                     valid_o,
  output csbw_pkg::smooth_req_t    res_o
);

  localparam int unsigned Last = csbw_pkg::DIV_STEPS - 1;

  csbw_pkg::div_stage_t             st_in [csbw_pkg::DIV_STEPS];
  csbw_pkg::div_stage_t             st_d  [csbw_pkg::DIV_STEPS];
  csbw_pkg::div_stage_t             st_q  [csbw_pkg::DIV_STEPS];
  logic [csbw_pkg::DIV_W-1:0]       rem_sh [csbw_pkg::DIV_STEPS];
  logic [csbw_pkg::DIV_STEPS-1:0]   take;
  logic [csbw_pkg::DIV_STEPS-1:0]   vld_q;

  always_comb begin
    st_in[0].is_div     = req_i.is_div;
    st_in[0].fix_weight = req_i.fix_weight;
    st_in[0].rem        = req_i.rem;
    st_in[0].den        = req_i.den;
    st_in[0].quot       = '0;
    for (int i = 1; i < csbw_pkg::DIV_STEPS; i++) begin
      st_in[i] = st_q[i-1];
    end
    for (int i = 0; i < csbw_pkg::DIV_STEPS; i++) begin
      // remainder stays below the divisor, so the shift never loses its top bit
      rem_sh[i] = {st_in[i].rem[csbw_pkg::DIV_W-2:0], 1'b0};
      take[i]   = (rem_sh[i] >= st_in[i].den);
      st_d[i]   = st_in[i];
      st_d[i].rem  = take[i] ? (rem_sh[i] - st_in[i].den) : rem_sh[i];
      st_d[i].quot = {st_in[i].quot[csbw_pkg::T_W-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[csbw_pkg::DIV_STEPS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < csbw_pkg::DIV_STEPS; i++) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign valid_o          = vld_q[Last];
  assign res_o.is_div     = st_q[Last].is_div;
  assign res_o.fix_weight = st_q[Last].fix_weight;
  assign res_o.quot       = st_q[Last].quot;

endmodule

`default_nettype wire

/* rtl/core/csbw_smooth.sv */
// Smoothstep t*t*(3-2t) with rounding, clamp and the output register.
`default_nettype none

module csbw_smooth (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  csbw_pkg::smooth_req_t                 req_i,
  output logic                                  valid_o,
  output logic [csbw_pkg::WEIGHT_W-1:0]         weight_o
);

  // Stage A: t*t and 3-2t.
  logic                            a_valid_q, a_is_div_q;
  logic [csbw_pkg::WEIGHT_W-1:0]   a_fix_q;
  logic [csbw_pkg::SQ_W-1:0]       a_sq_q;
  logic [csbw_pkg::M_W-1:0]        a_m_q, a_m_d;

  assign a_m_d = csbw_pkg::THREE_ONE - {1'b0, req_i.quot, 1'b0};

  // Stage B: full product.
  logic                            b_valid_q, b_is_div_q;
  logic [csbw_pkg::WEIGHT_W-1:0]   b_fix_q;
  logic [csbw_pkg::P_W-1:0]        b_p_q;

  // Output stage: round to nearest, clamp to one.
  logic [csbw_pkg::P_W-1:0]        p_rnd;
  logic [csbw_pkg::M_W-1:0]        s_val;
  logic [csbw_pkg::WEIGHT_W-1:0]   weight_d;

  always_comb begin
    p_rnd    = b_p_q + csbw_pkg::ROUND_HALF;
    s_val    = p_rnd[csbw_pkg::P_W-1:csbw_pkg::SQ_W];
    weight_d = b_fix_q;
    if (b_is_div_q) begin
      weight_d = (s_val > csbw_pkg::M_W'(csbw_pkg::WEIGHT_ONE)) ? csbw_pkg::WEIGHT_ONE
                                                             : s_val[csbw_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      valid_o   <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_is_div_q <= req_i.is_div;
      a_fix_q    <= req_i.fix_weight;
      a_sq_q     <= csbw_pkg::SQ_W'(req_i.quot) * csbw_pkg::SQ_W'(req_i.quot);
      a_m_q      <= a_m_d;

      b_is_div_q <= a_is_div_q;
      b_fix_q    <= a_fix_q;
      b_p_q      <= csbw_pkg::P_W'(a_sq_q) * csbw_pkg::P_W'(a_m_q);

      weight_o   <= weight_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cascade_shadow_blend_weight.sv */
// Top level of the cascade shadow blend weight pipeline.
//
// Usage:
//   Input channel: one beat per pixel, boundary_index_i and view_depth_i
//   (unsigned Q16.16), qualified by in_valid_i; the block holds off with
//   in_stall_o. Output channel: one beat per input beat, blend_weight_o in
//   unsigned Q1.16 (65536 is one), qualified by out_valid_o, held off by
//   out_stall_i. Results leave in input order.
//   Configuration: write cfg_data_i to register cfg_index_i when cfg_we_i is
//   high; write only while the pipeline is empty.
//   Throughput: one beat per cycle, sustained, while out_stall_i is low.
//   Pipeline from acceptance to out_valid_o: five front-end stages
//   (edge select, minimum, band multiply, numerator, classification), sixteen
//   divider stages (one quotient bit each, set by the 50-bit restoring
//   subtract) and three smoothstep stages ending in the output register.
//   Stall: when a result waits in the output register and out_stall_i is high,
//   every stage holds and in_stall_o rises in the same cycle; nothing is lost
//   or repeated. Bubbles in the pipeline are not squeezed out.
//   Reset: rst_ni clears all valid bits at once and loads the configuration
//   reset values; the block takes beats in the first cycle after reset.
`default_nettype none

module cascade_shadow_blend_weight (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [csbw_pkg::INDEX_W-1:0]      boundary_index_i,
  input  wire logic [csbw_pkg::EDGE_W-1:0]       view_depth_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [csbw_pkg::WEIGHT_W-1:0]          blend_weight_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [csbw_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [csbw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  csbw_pkg::cfg_t        cfg;
  csbw_pkg::div_req_t    div_req;
  csbw_pkg::smooth_req_t smooth_req;
  logic                  front_valid, div_valid;
  logic                  pipe_en;

  // Advance every stage unless a finished beat is stuck at the output.
  assign pipe_en    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !pipe_en;

  csbw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Band set-up: thinner cascade, half band, numerator over denominator.
  csbw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (pipe_en),
    .cfg_i            (cfg),
    .valid_i          (in_valid_i),
    .boundary_index_i (boundary_index_i),
    .view_depth_i     (view_depth_i),
    .valid_o          (front_valid),
    .req_o            (div_req)
  );

  // t = floor(num * 2^16 / den), only used when the depth lies inside the band.
  csbw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (front_valid),
    .req_i   (div_req),
    .valid_o (div_valid),
    .res_o   (smooth_req)
  );

  csbw_smooth u_smooth (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (div_valid),
    .req_i    (smooth_req),
    .valid_o  (out_valid_o),
    .weight_o (blend_weight_o)
  );

endmodule

`default_nettype wire

/* rtl/core/csbw_checker.sv */
// Port-level checker for the blend weight pipeline, bound to the top level.
`default_nettype none

module csbw_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [csbw_pkg::WEIGHT_W-1:0]     blend_weight_o
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // Weight never exceeds one.
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (blend_weight_o <= csbw_pkg::WEIGHT_ONE))
    else $error("blend weight above one");

  // Input is held off exactly when a result is stuck at the output.
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output back-pressure");

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(blend_weight_o)))
    else $error("stalled result changed");

endmodule

bind cascade_shadow_blend_weight csbw_checker u_csbw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .blend_weight_o (blend_weight_o)
);

`default_nettype wire
